// ----- hw/rtl/bcss_pkg.sv -----
// Shared widths, constants and register map of the batched C-SCAN seek scheduler.
package bcss_pkg;

	localparam int TRACK_W = 12;
	localparam int TOTAL_W = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TRACK_W-1:0] END_TRACK_RESET = 12'd200;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Register index, taken from paddr[2].
	localparam logic REG_END_TRACK = 1'b0;

endpackage

// ----- hw/rtl/bcss_if.sv -----
// Request and result channel interfaces of the seek scheduler.
interface bcss_req_if;
	logic valid;
	logic ready;
	logic [bcss_pkg::TRACK_W-1:0] track;
	logic last_in_batch;

	modport source(output valid, output track, output last_in_batch, input ready);
	modport sink(input valid, input track, input last_in_batch, output ready);
endinterface

interface bcss_res_if;
	logic valid;
	logic ready;
	logic [bcss_pkg::TRACK_W-1:0] distance;
	logic [bcss_pkg::TOTAL_W-1:0] total_seek;
	logic last_of_batch;
	logic rejected;

	modport source(output valid, output distance, output total_seek, output last_of_batch,
		output rejected, input ready);
	modport sink(input valid, input distance, input total_seek, input last_of_batch,
		input rejected, output ready);
endinterface

// ----- hw/rtl/batched_cscan_seek_scheduler.sv -----
// Top level of the batched C-SCAN seek scheduler.
// A request that does not close a batch is stored, or rejected with a result. A closing request
// starts a sweep: for n stored tracks with k distinct values the stored batch is scanned k times
// through the single RAM read port, and each track served yields a result. No request is taken
// meanwhile.
// Reset clears the batch count, head, seek total and output valid flag; end_track returns to 200.
module batched_cscan_seek_scheduler #(
	parameter int BATCH_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bcss_req_if.sink                     req,
	bcss_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bcss_pkg::PADDR_W-1:0] paddr,
	input  logic [bcss_pkg::PDATA_W-1:0] pwdata,
	output logic [bcss_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int AW = $clog2(BATCH_DEPTH);
	localparam int CW = $clog2(BATCH_DEPTH + 1);
	localparam int TW = bcss_pkg::TRACK_W;
	localparam int SW = bcss_pkg::TOTAL_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_TAIL
	} state_t;

	state_t state_q;

	logic [TW-1:0] end_track_q;
	logic [CW-1:0] count_q;
	logic [TW-1:0] head_q;
	logic [SW-1:0] total_q;

	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_idx_q;
	logic          issue_s1;
	logic [TW-1:0] prev_q;
	logic          have_prev_q;
	logic [TW-1:0] min_q;
	logic          found_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] served_q;
	logic [TW-1:0] dist_q;
	logic          rej_q;

	logic          res_valid_q;
	logic [TW-1:0] res_distance_q;
	logic [SW-1:0] res_total_q;
	logic          res_last_q;
	logic          res_rej_q;

	logic          res_free;
	logic          req_acc;
	logic          req_rej;
	logic          ram_we;
	logic [TW-1:0] ram_rdata;
	logic          rd_issue;
	logic          cand;
	logic [TW-1:0] step_dist;
	logic [TW-1:0] tail_dist;
	logic [TW-1:0] addend;
	logic [SW:0]   sum_raw;
	logic [SW-1:0] sum_sat;
	logic          cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == bcss_pkg::REG_END_TRACK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_track_q <= bcss_pkg::END_TRACK_RESET;
		end else if (cfg_wr) begin
			end_track_q <= pwdata[TW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bcss_pkg::REG_END_TRACK) begin
			prdata = {{(bcss_pkg::PDATA_W - TW){1'b0}}, end_track_q};
		end
	end

	// Handshake and request decode.
	assign res_free  = !res_valid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && res_free;
	assign req_acc   = req.valid && req.ready;
	assign req_rej   = (req.track > end_track_q) || (count_q == CW'(BATCH_DEPTH));
	assign ram_we    = req_acc && !req_rej;
	assign rd_issue  = (state_q == ST_SCAN) && (rd_idx_q < n_q);

	bcss_ram #(
		.WIDTH(TW),
		.DEPTH(BATCH_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(req.track),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Each scan looks for the smallest stored track above the last one served.
	assign cand = !have_prev_q || (ram_rdata > prev_q);

	// The shared saturating adder serves both the step distance and the sweep tail.
	assign step_dist = min_q - head_q;
	assign tail_dist = (end_track_q > head_q) ? (end_track_q - head_q) : '0;
	assign addend    = (state_q == ST_TAIL) ? tail_dist : step_dist;
	assign sum_raw   = {1'b0, total_q} + {{(SW + 1 - TW){1'b0}}, addend};
	assign sum_sat   = sum_raw[SW] ? bcss_pkg::TOTAL_MAX : sum_raw[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			total_q     <= '0;
			n_q         <= '0;
			rd_idx_q    <= '0;
			issue_s1    <= 1'b0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			served_q    <= '0;
			rej_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (!req_rej) begin
							count_q <= count_q + CW'(1);
						end
						if (!req.last_in_batch) begin
							if (req_rej) begin
								res_valid_q    <= 1'b1;
								res_distance_q <= '0;
								res_total_q    <= total_q;
								res_last_q     <= 1'b0;
								res_rej_q      <= 1'b1;
							end
						end else begin
							rej_q       <= req_rej;
							n_q         <= count_q + CW'(!req_rej);
							rd_idx_q    <= '0;
							issue_s1    <= 1'b0;
							have_prev_q <= 1'b0;
							found_q     <= 1'b0;
							served_q    <= '0;
							dist_q      <= '0;
							if ((count_q + CW'(!req_rej)) == '0) begin
								state_q <= ST_TAIL;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					issue_s1 <= rd_issue;
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (issue_s1 && cand) begin
						if (!found_q || (ram_rdata < min_q)) begin
							min_q   <= ram_rdata;
							cnt_q   <= CW'(1);
							found_q <= 1'b1;
						end else if (ram_rdata == min_q) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					if (!rd_issue && !issue_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						head_q   <= min_q;
						total_q  <= sum_sat;
						served_q <= served_q + CW'(1);
						cnt_q    <= cnt_q - CW'(1);
						if ((served_q + CW'(1)) == n_q) begin
							dist_q  <= step_dist;
							state_q <= ST_TAIL;
						end else begin
							res_valid_q    <= 1'b1;
							res_distance_q <= step_dist;
							res_total_q    <= sum_sat;
							res_last_q     <= 1'b0;
							res_rej_q      <= 1'b0;
							if (cnt_q == CW'(1)) begin
								prev_q      <= min_q;
								have_prev_q <= 1'b1;
								rd_idx_q    <= '0;
								issue_s1    <= 1'b0;
								found_q     <= 1'b0;
								state_q     <= ST_SCAN;
							end
						end
					end
				end
				ST_TAIL: begin
					if (res_free) begin
						total_q        <= sum_sat;
						res_valid_q    <= 1'b1;
						res_distance_q <= dist_q;
						res_total_q    <= sum_sat;
						res_last_q     <= 1'b1;
						res_rej_q      <= rej_q;
						head_q         <= '0;
						count_q        <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = res_valid_q;
	assign res.distance      = res_distance_q;
	assign res.total_seek    = res_total_q;
	assign res.last_of_batch = res_last_q;
	assign res.rejected      = res_rej_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BATCH_DEPTH))
		else $error("batch count exceeds the store depth");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready)
		else $error("request taken while a sweep is running");

	a_emit_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (found_q && (cnt_q != '0) && (served_q < n_q)))
		else $error("serving without a pending minimum");

	a_tail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL && res_free) |=> (count_q == '0 && head_q == '0 && res_valid_q
			&& res_last_q))
		else $error("sweep end did not clear the batch and head");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_TAIL) |=> (total_q >= $past(total_q)))
		else $error("seek total decreased");

endmodule

// ----- hw/rtl/bcss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bcss_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
